// ----- rtl/tlzw_pkg.sv -----
// ----------------------------------------------------------------------------
// tlzw_pkg
// Shared types and constants for the TIFF LZW decoder unit.
// ----------------------------------------------------------------------------
package tlzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_DEPTH   = 4096;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int CNT_W         = 13;

    localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
    localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
    localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;
    localparam logic [3:0]        START_BITS = 4'd9;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DECODE,
        PH_DRAIN,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        FIN_OK,
        FIN_END,
        FIN_BAD
    } fin_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_LEADC,
        S_LEADP,
        S_WALK,
        S_WALKD,
        S_ADD,
        S_FIN,
        S_POPD,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic pop_req;
        logic pop_done;
        logic idle_result;
        logic feed;
        logic clear;
        logic fin;
        fin_t fin_code;
        logic rd_code;
        logic grab_leadc;
        logic grab_leadp;
        logic walk_rd;
        logic walk_pop;
        logic walk_end;
        logic add;
    } dp_cmd_t;

    typedef struct packed {
        logic can_pop;
        logic can_feed;
        logic have_code;
        logic is_clear;
        logic is_end;
        logic known;
        logic prev_ok;
        logic walk_ext;
    } dp_stat_t;

endpackage

// ----- rtl/tiff_lzw_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tiff_lzw_decoder_unit
// TIFF LZW decoder (9 to 12 bit codes, early change) with a byte output stack.
// ----------------------------------------------------------------------------
// One transaction in, one result transaction out. A fetch steps through
// stack read, result and hand-off. A fed byte that completes a data code
// walks the code's prefix chain, reading the single-port string table once
// per step; other feeds only classify the code before their result. The
// result is held until taken, and no new transaction is accepted before that.
module tiff_lzw_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        out_valid,
    output logic        out_last,
    output logic        chunk_done,
    output logic [1:0]  status,
    output logic [12:0] pending_count
);
    import tlzw_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tlzw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlzw_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode),
        .data_byte     (data_byte),
        .final_byte    (final_byte),
        .cmd           (cmd),
        .stat          (stat),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .out_last      (out_last),
        .chunk_done    (chunk_done),
        .status        (status),
        .pending_count (pending_count)
    );

endmodule

// ----- rtl/tlzw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlzw_ctrl
// Sequencer: steps one transaction through decode, chain walk and delivery.
// ----------------------------------------------------------------------------
module tlzw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              res_valid,
    input  logic              res_stall,
    input  tlzw_pkg::dp_stat_t stat,
    output tlzw_pkg::dp_cmd_t  cmd
);
    import tlzw_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.fin_code = FIN_OK;
        in_stall   = (state_reg != S_IDLE);
        res_valid  = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.can_pop)
                    begin
                        cmd.pop_req = 1'b1;
                        state_next  = S_POPD;
                    end
                    else if (stat.can_feed)
                    begin
                        cmd.feed   = 1'b1;
                        state_next = S_CLASS;
                    end
                    else
                    begin
                        cmd.idle_result = 1'b1;
                        state_next      = S_OUT;
                    end
                end
            end
            S_CLASS:
            begin
                priority if (!stat.have_code)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.is_clear)
                begin
                    cmd.clear  = 1'b1;
                    cmd.fin    = 1'b1;
                    state_next = S_OUT;
                end
                else if (stat.is_end)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = FIN_END;
                    state_next   = S_OUT;
                end
                else if (!stat.known && !stat.prev_ok)
                begin
                    cmd.fin      = 1'b1;
                    cmd.fin_code = FIN_BAD;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.rd_code = 1'b1;
                    state_next  = S_LEADC;
                end
            end
            S_LEADC:
            begin
                cmd.grab_leadc = 1'b1;
                state_next     = S_LEADP;
            end
            S_LEADP:
            begin
                cmd.grab_leadp = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_ext)
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALKD;
                end
                else
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = S_ADD;
                end
            end
            S_WALKD:
            begin
                cmd.walk_pop = 1'b1;
                state_next   = S_WALK;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_POPD:
            begin
                cmd.pop_done = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!res_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/tlzw_dp.sv -----
// ----------------------------------------------------------------------------
// tlzw_dp
// Datapath: bit unpacker, string table, output stack and result registers.
// ----------------------------------------------------------------------------
module tlzw_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    input  tlzw_pkg::dp_cmd_t  cmd,
    output tlzw_pkg::dp_stat_t stat,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic              out_last,
    output logic              chunk_done,
    output logic [1:0]        status,
    output logic [12:0]       pending_count
);
    import tlzw_pkg::*;

    logic [27:0] tbl_mem [TABLE_DEPTH];
    logic [7:0]  stk_mem [TABLE_DEPTH];
    logic [27:0] tbl_rd;
    logic [7:0]  stk_rd;
    logic [CODE_W-1:0] tbl_addr;
    logic [CODE_W-1:0] stk_raddr;

    logic [11:0]       buf_reg, buf_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [3:0]        cw_reg, cw_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic              pv_reg, pv_next;
    logic [CNT_W-1:0]  nf_reg, nf_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    phase_t            phase_reg, phase_next;
    logic              produced_reg, produced_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              have_reg, have_next;
    logic              fin_reg, fin_next;
    logic [7:0]        leadc_reg, leadc_next;
    logic [7:0]        leadp_reg, leadp_next;
    logic [7:0]        lead_reg, lead_next;
    logic [CODE_W-1:0] walk_reg, walk_next;
    logic [7:0]        ob_reg, ob_next;
    logic              ov_reg, ov_next;
    logic              ol_reg, ol_next;
    logic [1:0]        os_reg, os_next;

    logic              push_en;
    logic [7:0]        push_data;
    logic              tbl_we;

    logic [11:0]       e_buf;
    logic [3:0]        e_cnt;
    logic [19:0]       acc;
    logic [4:0]        cnt8;
    logic [4:0]        rem_cnt;
    logic [19:0]       shifted;
    logic [12:0]       cw_mask;
    logic [7:0]        leadp_now;
    logic [CNT_W-1:0]  nf_inc;
    logic [CNT_W-1:0]  cw_pow;

    assign stat.can_pop   = mode && (depth_reg != '0);
    assign stat.can_feed  = !mode && (phase_reg != PH_DISCARD) && (depth_reg == '0);
    assign stat.have_code = have_reg;
    assign stat.is_clear  = (code_reg == CODE_CLEAR);
    assign stat.is_end    = (code_reg == CODE_END);
    assign stat.known     = (code_reg < 12'd256) ||
                            ((code_reg >= FIRST_FREE) && ({1'b0, code_reg} < nf_reg));
    assign stat.prev_ok   = pv_reg && ({1'b0, prev_reg} < nf_reg);
    assign stat.walk_ext  = (walk_reg >= FIRST_FREE);

    assign stk_raddr = depth_reg[CODE_W-1:0] - 12'd1;
    assign tbl_we    = cmd.add && stat.prev_ok && (nf_reg < CNT_W'(TABLE_DEPTH));

    always_comb
    begin
        tbl_addr = '0;
        if (cmd.rd_code)
            tbl_addr = code_reg;
        else if (cmd.grab_leadc)
            tbl_addr = prev_reg;
        else if (cmd.walk_rd)
            tbl_addr = walk_reg;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[nf_reg[CODE_W-1:0]] <= {prev_reg, lead_reg, leadp_reg};
        tbl_rd <= tbl_mem[tbl_addr];
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
            stk_mem[depth_reg[CODE_W-1:0]] <= push_data;
        stk_rd <= stk_mem[stk_raddr];
    end

    assign e_buf   = (phase_reg == PH_IDLE) ? 12'd0 : buf_reg;
    assign e_cnt   = (phase_reg == PH_IDLE) ? 4'd0 : cnt_reg;
    assign acc     = {e_buf, data_byte};
    assign cnt8    = {1'b0, e_cnt} + 5'd8;
    assign rem_cnt = cnt8 - {1'b0, ((phase_reg == PH_IDLE) ? START_BITS : cw_reg)};
    assign shifted = acc >> rem_cnt;
    assign cw_mask = (13'd1 << ((phase_reg == PH_IDLE) ? START_BITS : cw_reg)) - 13'd1;
    assign leadp_now = (prev_reg < 12'd256) ? prev_reg[7:0] : tbl_rd[7:0];
    assign nf_inc  = nf_reg + 13'd1;
    assign cw_pow  = 13'd1 << cw_reg;

    always_comb
    begin
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        cw_next       = cw_reg;
        prev_next     = prev_reg;
        pv_next       = pv_reg;
        nf_next       = nf_reg;
        depth_next    = depth_reg;
        phase_next    = phase_reg;
        produced_next = produced_reg;
        code_next     = code_reg;
        have_next     = have_reg;
        fin_next      = fin_reg;
        leadc_next    = leadc_reg;
        leadp_next    = leadp_reg;
        lead_next     = lead_reg;
        walk_next     = walk_reg;
        ob_next       = ob_reg;
        ov_next       = ov_reg;
        ol_next       = ol_reg;
        os_next       = os_reg;
        push_en       = 1'b0;
        push_data     = 8'd0;

        if (cmd.idle_result)
        begin
            ob_next = 8'd0;
            ov_next = 1'b0;
            ol_next = 1'b0;
            os_next = ST_OK;
            if (!mode && phase_reg != PH_DISCARD)
                os_next = ST_REFUSED;
            if (!mode && phase_reg == PH_DISCARD && final_byte)
                phase_next = PH_IDLE;
        end

        if (cmd.pop_req)
            depth_next = depth_reg - 13'd1;

        if (cmd.pop_done)
        begin
            ob_next = stk_rd;
            ov_next = 1'b1;
            ol_next = 1'b0;
            os_next = ST_OK;
            if (phase_reg == PH_DRAIN && depth_reg == '0)
            begin
                ol_next    = 1'b1;
                phase_next = PH_IDLE;
            end
        end

        if (cmd.feed)
        begin
            fin_next = final_byte;
            if (phase_reg == PH_IDLE)
            begin
                cw_next       = START_BITS;
                prev_next     = '0;
                pv_next       = 1'b0;
                nf_next       = {1'b0, FIRST_FREE};
                produced_next = 1'b0;
                phase_next    = PH_DECODE;
            end
            if (!rem_cnt[4] && cnt8 >= {1'b0, ((phase_reg == PH_IDLE) ? START_BITS : cw_reg)})
            begin
                have_next = 1'b1;
                code_next = shifted[11:0] & cw_mask[11:0];
                buf_next  = acc[11:0] & ((12'd1 << rem_cnt[3:0]) - 12'd1);
                cnt_next  = rem_cnt[3:0];
            end
            else
            begin
                have_next = 1'b0;
                buf_next  = acc[11:0];
                cnt_next  = cnt8[3:0];
            end
        end

        if (cmd.clear)
        begin
            nf_next = {1'b0, FIRST_FREE};
            cw_next = START_BITS;
            pv_next = 1'b0;
        end

        if (cmd.grab_leadc)
            leadc_next = (code_reg < 12'd256) ? code_reg[7:0] : tbl_rd[7:0];

        if (cmd.grab_leadp)
        begin
            leadp_next = leadp_now;
            lead_next  = stat.known ? leadc_reg : leadp_now;
            walk_next  = stat.known ? code_reg : prev_reg;
            if (!stat.known)
            begin
                push_en   = 1'b1;
                push_data = leadp_now;
            end
        end

        if (cmd.walk_pop)
        begin
            push_en   = 1'b1;
            push_data = tbl_rd[15:8];
            walk_next = tbl_rd[27:16];
        end

        if (cmd.walk_end)
        begin
            push_en   = 1'b1;
            push_data = walk_reg[7:0];
        end

        if (push_en)
        begin
            if (depth_reg < CNT_W'(TABLE_DEPTH))
                depth_next = depth_reg + 13'd1;
            else
                push_en = 1'b0;
        end

        if (cmd.add)
        begin
            produced_next = 1'b1;
            prev_next     = code_reg;
            pv_next       = 1'b1;
            if (tbl_we)
            begin
                nf_next = nf_inc;
                if ((nf_inc + 13'd1 >= cw_pow) && (cw_reg < 4'(MAX_CODE_BITS)))
                    cw_next = cw_reg + 4'd1;
            end
            else if ((nf_inc >= cw_pow) && (cw_reg < 4'(MAX_CODE_BITS)))
                cw_next = cw_reg + 4'd1;
        end

        if (cmd.fin)
        begin
            ob_next = 8'd0;
            ov_next = 1'b0;
            ol_next = 1'b0;
            unique case (cmd.fin_code)
                FIN_BAD:
                begin
                    phase_next = fin_reg ? PH_IDLE : PH_DISCARD;
                    os_next    = ST_BAD;
                end
                FIN_END:
                begin
                    phase_next = fin_reg ? PH_IDLE : PH_DISCARD;
                    os_next    = produced_reg ? ST_OK : ST_EMPTY;
                end
                default:
                begin
                    if (fin_reg)
                    begin
                        phase_next = (depth_reg != '0) ? PH_DRAIN : PH_IDLE;
                        os_next    = produced_reg ? ST_OK : ST_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_DECODE;
                        os_next    = ST_OK;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= '0;
            cnt_reg      <= '0;
            cw_reg       <= START_BITS;
            prev_reg     <= '0;
            pv_reg       <= 1'b0;
            nf_reg       <= {1'b0, FIRST_FREE};
            depth_reg    <= '0;
            phase_reg    <= PH_IDLE;
            produced_reg <= 1'b0;
            have_reg     <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            buf_reg      <= buf_next;
            cnt_reg      <= cnt_next;
            cw_reg       <= cw_next;
            prev_reg     <= prev_next;
            pv_reg       <= pv_next;
            nf_reg       <= nf_next;
            depth_reg    <= depth_next;
            phase_reg    <= phase_next;
            produced_reg <= produced_next;
            have_reg     <= have_next;
            fin_reg      <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        leadc_reg <= leadc_next;
        leadp_reg <= leadp_next;
        lead_reg  <= lead_next;
        walk_reg  <= walk_next;
        ob_reg    <= ob_next;
        ov_reg    <= ov_next;
        ol_reg    <= ol_next;
        os_reg    <= os_next;
    end

    assign out_byte      = ob_reg;
    assign out_valid     = ov_reg;
    assign out_last      = ol_reg;
    assign status        = os_reg;
    assign chunk_done    = (phase_reg == PH_IDLE);
    assign pending_count = depth_reg;

endmodule
